@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers included by the stack core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: implication does not hold");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication does not hold");

`endif

@@ rtl/core/stk_pkg.sv @@
// ----------------------------------------------------------------------------
// stk_pkg
// operation codes, status codes and field widths of the lifo stack core
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  // default stack depth
  localparam int DEF_MAX_DEPTH = 128;

  // field widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 7;
  localparam int COUNT_W  = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH        = 3'd0;
  localparam logic [OP_W-1:0] OP_POP         = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_UNIQUE = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND        = 3'd3;
  localparam logic [OP_W-1:0] OP_READ        = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/stack_with_unique_push_core.sv @@
// ----------------------------------------------------------------------------
// stack_with_unique_push_core
// bounded lifo stack of signed 32-bit items with push, pop, push-if-absent,
// find (lowest matching index, linear scan from the bottom) and indexed read
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid / in_ready   | operation, item, position
//   out     | output    | out_valid / out_ready | status, value, found,
//           |           |                       | found_index, count
//
// push and the no-op codes pass through the exec and done states to the
// output register; a pop or indexed read that succeeds adds a load state (one
// registered read of the entry memory). find and push-if-absent scan the held
// entries through one comparator, one entry per cycle. reset (rst, synchronous)
// empties the stack; entries need no clearing. a new request is taken while
// a finished result still waits at the output; the result waits in the done
// state only when the output register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stack_with_unique_push_core #(
  parameter int MAX_DEPTH = stk_pkg::DEF_MAX_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst,
  // request channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [stk_pkg::OP_W-1:0]          operation,
  input  wire  signed [stk_pkg::DATA_W-1:0] item,
  input  wire  [stk_pkg::POS_W-1:0]         position,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [stk_pkg::STATUS_W-1:0]      status,
  output logic signed [stk_pkg::DATA_W-1:0] value,
  output logic                              found,
  output logic [stk_pkg::FIDX_W-1:0]        found_index,
  output logic [stk_pkg::COUNT_W-1:0]       count
);

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int IW = $clog2(MAX_DEPTH);
  localparam int PW = (CW > stk_pkg::POS_W) ? CW : stk_pkg::POS_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  // latched request
  logic [stk_pkg::OP_W-1:0]   op_r;
  logic [stk_pkg::DATA_W-1:0] item_r;
  logic [stk_pkg::POS_W-1:0]  pos_r;

  // stack state
  logic [stk_pkg::DATA_W-1:0] mem [MAX_DEPTH];
  logic [stk_pkg::DATA_W-1:0] rd_data;
  logic [CW-1:0]              depth_used;

  // scan pointer and the compare stage behind the memory read
  logic [CW-1:0] scan_idx;
  logic          cmp_pend;
  logic [IW-1:0] cmp_idx;

  // result held until the output register is free
  logic [stk_pkg::STATUS_W-1:0] res_status;
  logic [stk_pkg::DATA_W-1:0]   res_value;
  logic                         res_found;
  logic [IW-1:0]                res_idx;

  // memory port controls
  logic                       mem_we;
  logic [IW-1:0]              mem_waddr;
  logic [IW-1:0]              rd_addr;
  logic                       is_full;
  logic                       is_empty;
  logic                       pos_ok;
  logic                       hit;
  logic                       scan_more;
  logic                       out_free;

  assign is_full   = (depth_used >= FULL);
  assign is_empty  = (depth_used == '0);
  assign pos_ok    = (PW'(pos_r) < PW'(depth_used));
  assign hit       = cmp_pend && (rd_data == item_r);
  assign scan_more = (scan_idx < depth_used);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign mem_waddr = depth_used[IW-1:0];

  // read address and write enable of the entry memory
  always_comb begin
    rd_addr = scan_idx[IW-1:0];
    mem_we  = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (op_r == stk_pkg::OP_POP) begin
          rd_addr = IW'(depth_used - CW'(1));
        end else if (op_r == stk_pkg::OP_READ) begin
          rd_addr = IW'(pos_r);
        end
        mem_we = (op_r == stk_pkg::OP_PUSH) && !is_full;
      end
      S_SCAN: begin
        mem_we = !hit && !scan_more && (op_r == stk_pkg::OP_PUSH_UNIQUE) && !is_full;
      end
      default: begin
      end
    endcase
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= item_r;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth_used <= '0;
      cmp_pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= operation;
            item_r <= item;
            pos_r  <= position;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= stk_pkg::ST_OK;
          res_value  <= '0;
          res_found  <= 1'b0;
          res_idx    <= '0;
          scan_idx   <= '0;
          cmp_pend   <= 1'b0;
          state      <= S_DONE;
          priority if (op_r == stk_pkg::OP_PUSH) begin
            if (is_full) begin
              res_status <= stk_pkg::ST_OVERFLOW;
            end else begin
              depth_used <= depth_used + CW'(1);
            end
          end else if (op_r == stk_pkg::OP_POP) begin
            if (is_empty) begin
              res_status <= stk_pkg::ST_UNDERFLOW;
            end else begin
              depth_used <= depth_used - CW'(1);
              state      <= S_LOAD;
            end
          end else if (op_r == stk_pkg::OP_READ) begin
            if (pos_ok) begin
              state <= S_LOAD;
            end else begin
              res_status <= stk_pkg::ST_RANGE;
            end
          end else if (op_r == stk_pkg::OP_PUSH_UNIQUE || op_r == stk_pkg::OP_FIND) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_LOAD: begin
          res_value <= rd_data;
          state     <= S_DONE;
        end
        S_SCAN: begin
          priority if (hit) begin
            res_found <= 1'b1;
            res_idx   <= cmp_idx;
            cmp_pend  <= 1'b0;
            state     <= S_DONE;
          end else if (scan_more) begin
            cmp_pend <= 1'b1;
            cmp_idx  <= scan_idx[IW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end else begin
            // scan missed: push-if-absent stores the item unless the stack is full
            cmp_pend <= 1'b0;
            state    <= S_DONE;
            if (op_r == stk_pkg::OP_PUSH_UNIQUE) begin
              if (is_full) begin
                res_status <= stk_pkg::ST_OVERFLOW;
              end else begin
                depth_used <= depth_used + CW'(1);
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      value       <= res_value;
      found       <= res_found;
      found_index <= stk_pkg::FIDX_W'(res_idx);
      count       <= stk_pkg::COUNT_W'(depth_used);
    end
  end

  // checks
  `ASSERT_ALWAYS(a_depth_bound, depth_used <= FULL)
  `ASSERT_IMPLIES(a_scan_bound, state == S_SCAN, scan_idx <= depth_used)
  `ASSERT_IMPLIES(a_overflow_full, state == S_DONE && res_status == stk_pkg::ST_OVERFLOW, is_full)
  `ASSERT_NEXT(a_request_starts, in_valid && in_ready, state == S_EXEC)

endmodule

`default_nettype wire
